FILE: sv/sosc_pkg.sv
// Package: shared types, constants and state codes for the odd-only segmented sieve counter.
`timescale 1ns / 1ps
package sosc_pkg;
  localparam int SegmentBits = 32768;
  localparam int SegIdxW = $clog2(SegmentBits);
  localparam int TableDepth = 131072;
  localparam int TabIdxW = $clog2(TableDepth);
  localparam int TabCntW = $clog2(TableDepth + 1);
  localparam int PrimeW = 20;
  localparam int BlockW = 24;
  localparam int CountW = 16;
  localparam int ValW = 48;   // holds high = (block+1)*2*SegmentBits and p*p
  localparam int SpanShift = $clog2(2 * SegmentBits);

  typedef struct packed {
    logic [BlockW-1:0] block_index;
    logic [PrimeW-1:0] prime_value;
    logic              req_type;
  } sosc_in_t;

  typedef struct packed {
    logic [BlockW-1:0] block_echo;
    logic [CountW-1:0] prime_count;
  } sosc_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_RD, S_RDW, S_CHK, S_MOD, S_MARK, S_CNT, S_CNTW, S_DONE
  } sosc_state_t;

  typedef struct packed {
    logic              start;
    logic [ValW-1:0]   dividend;
    logic [PrimeW-1:0] divisor;
  } sosc_div_req_t;

  typedef struct packed {
    logic              done;
    logic [PrimeW-1:0] rem;
  } sosc_div_rsp_t;
endpackage

FILE: sv/sosc_divider.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module sosc_divider import sosc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  sosc_div_req_t req,
  output sosc_div_rsp_t rsp
);
  localparam int CntW = $clog2(ValW + 1);
  logic [ValW-1:0]   dvd;
  logic [PrimeW:0]   r;
  logic [PrimeW-1:0] d;
  logic [CntW-1:0]   cnt;
  logic              run;
  logic              done_q;
  logic [PrimeW+1:0] shifted;

  assign shifted = {r, dvd[ValW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        dvd <= req.dividend;
        d <= req.divisor;
        r <= '0;
        cnt <= CntW'(ValW);
      end else if (run) begin
        dvd <= {dvd[ValW-2:0], 1'b0};
        if (shifted >= {2'b00, d}) r <= (PrimeW+1)'(shifted - {2'b00, d});
        else r <= shifted[PrimeW:0];
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          run <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_q, rem: r[PrimeW-1:0]};
endmodule

FILE: sv/segmented_odd_prime_sieve_counter_core.sv
// Top level: odd-only segmented sieve, with a bit-serial remainder unit under a small sequencer.
`timescale 1ns / 1ps
// Each sieve transaction runs a fill sweep over the segment bitmap, then walks the
// base-prime table: read, read wait and check for each entry, plus a pass
// through the bit-serial remainder unit when the block starts at or above p*p,
// plus one bitmap write per cleared bit (about SegmentBits/p) and a final step
// to close the entry. The walk ends when the table runs out or p*p reaches the
// top of the block; a count sweep and a result state follow. The total therefore
// grows with the number of base primes walked and is far larger for high blocks
// with a large table. The result is shown with done for exactly one cycle and
// is taken then: the receiver cannot stall it. busy stays high for the whole
// sieve, result cycle included.
module segmented_odd_prime_sieve_counter_core import sosc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sosc_in_t  in_item,
  output logic      busy,
  output logic      done,
  output sosc_out_t result
);
  sosc_state_t state, state_next;

  // Base-prime table and odd bitmap: registered reads.
  logic [PrimeW-1:0] table_mem [TableDepth];
  logic              bitmap [SegmentBits];
  logic [PrimeW-1:0] tab_rd;
  logic              bm_rd;

  logic [TabCntW-1:0] loaded;
  logic [TabCntW-1:0] idx;
  logic [BlockW-1:0]  blk;
  logic [ValW-1:0]    low, high, psq;
  logic [PrimeW-1:0]  p;
  logic [SegIdxW:0]   j;       // one extra bit to detect end of segment
  logic [SegIdxW:0]   ptr;
  logic [CountW:0]    cnt;
  logic [ValW-1:0]    start_v;
  sosc_div_req_t      dreq;
  sosc_div_rsp_t      drsp;
  logic               accept;
  logic [ValW-1:0]    psq_c;
  logic [ValW-1:0]    base_c;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  sosc_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign psq_c = ValW'(tab_rd) * ValW'(tab_rd);
  assign dreq.start = (state == S_CHK) && (p != '0) && (p != PrimeW'(2)) && (psq < high)
                      && (low >= psq);
  assign dreq.dividend = low;
  assign dreq.divisor = p;

  // First odd multiple at or above max(low, p*p); the bitmap index is taken from it below.
  always_comb begin
    base_c = psq;
    if (state == S_MOD)
      base_c = (drsp.rem == '0) ? low : low + ValW'(p - drsp.rem);
    start_v = base_c[0] ? base_c : base_c + ValW'(p);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && in_item.req_type) state_next = S_FILL;
      S_FILL: if (ptr == (SegIdxW+1)'(SegmentBits - 1)) state_next = S_RD;
      S_RD:   state_next = (idx < loaded) ? S_RDW : S_CNT;
      S_RDW:  state_next = S_CHK;
      S_CHK: begin
        if (p == PrimeW'(2) || p == '0) state_next = S_RD;
        else if (psq >= high) state_next = S_CNT;
        else if (low >= psq) state_next = S_MOD;
        else state_next = S_MARK;
      end
      S_MOD:  if (drsp.done) state_next = S_MARK;
      S_MARK: if (j[SegIdxW]) state_next = S_RD;
      S_CNT:  state_next = S_CNTW;
      S_CNTW: if (ptr[SegIdxW]) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done = (state == S_DONE);
    result.block_echo = blk;
    result.prime_count = cnt[CountW] ? '1 : cnt[CountW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (accept && !in_item.req_type && loaded < TabCntW'(TableDepth)) begin
      loaded <= loaded + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_item.req_type && loaded < TabCntW'(TableDepth))
      table_mem[loaded[TabIdxW-1:0]] <= in_item.prime_value;
    tab_rd <= table_mem[idx[TabIdxW-1:0]];
  end

  // Bitmap: set during fill, clear during marking, read during count.
  always_ff @(posedge clk) begin
    if (state == S_FILL) bitmap[ptr[SegIdxW-1:0]] <= 1'b1;
    else if (state == S_MARK && !j[SegIdxW]) bitmap[j[SegIdxW-1:0]] <= 1'b0;
    bm_rd <= bitmap[ptr[SegIdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ptr <= '0;
        idx <= '0;
        cnt <= '0;
        if (accept && in_item.req_type) begin
          blk <= in_item.block_index;
          low <= ValW'(in_item.block_index) << SpanShift;
          high <= (ValW'(in_item.block_index) + 1'b1) << SpanShift;
        end
      end
      S_FILL: ptr <= ptr + 1'b1;
      S_RD:   idx <= idx + 1'b1;
      S_RDW: begin
        p <= tab_rd;
        psq <= psq_c;
      end
      // Start at p*p; a first multiple past the segment marks nothing.
      S_CHK: if (low < psq) begin
        if (((start_v - low) >> 1) >= ValW'(SegmentBits)) j <= {1'b1, {SegIdxW{1'b0}}};
        else j <= (SegIdxW+1)'((start_v - low) >> 1);
      end
      S_MOD: if (drsp.done) begin
        // start - low stays below 2p + 2, so narrow index is safe
        if (((start_v - low) >> 1) >= ValW'(SegmentBits)) j <= {1'b1, {SegIdxW{1'b0}}};
        else j <= (SegIdxW+1)'((start_v - low) >> 1);
      end
      S_MARK: if (!j[SegIdxW]) begin
        if (ValW'(j) + ValW'(p) >= ValW'(SegmentBits)) j <= {1'b1, {SegIdxW{1'b0}}};
        else j <= j + (SegIdxW+1)'(p);
      end
      S_CNT: ptr <= (SegIdxW+1)'(1);
      S_CNTW: begin
        cnt <= cnt + (CountW+1)'(bm_rd);
        ptr <= ptr + 1'b1;
      end
      default: ;
    endcase
    if (state == S_RD && !(idx < loaded)) ptr <= '0;
  end
endmodule
